### hdl/cwl_pkg.sv
// Shared types and command codes for the connection wildcard lookup chain.
package cwl_pkg;

  localparam logic [1:0] CMD_WRITE      = 2'd0;
  localparam logic [1:0] CMD_INVALIDATE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP     = 2'd2;

  localparam int SLOT_W = 4;
  localparam int PORT_W = 16;
  localparam int HOST_W = 48;

  // Word travelling down the row of cells: the command, its query and the best match so far.
  typedef struct packed {
    logic              valid;
    logic [1:0]        command;
    logic [SLOT_W-1:0] slot;
    logic [PORT_W-1:0] local_port;
    logic [HOST_W-1:0] remote_host;
    logic [PORT_W-1:0] remote_port;
    logic              allow_wildcard;
    logic              exact_found;
    logic [SLOT_W-1:0] exact_slot;
    logic              wild_found;
    logic [SLOT_W-1:0] wild_slot;
  } token_t;

endpackage

### hdl/cwl_cell.sv
// One connection slot: holds its entry and scores the passing word against it.
module cwl_cell #(
  parameter int IDX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  cwl_pkg::token_t tok_in,
  output cwl_pkg::token_t tok_out
);

  localparam logic [cwl_pkg::SLOT_W-1:0] SLOT_ID = cwl_pkg::SLOT_W'(IDX);
  // Only slots that a 4-bit index can name are ever written.
  localparam bit ADDRESSABLE = (IDX < (1 << cwl_pkg::SLOT_W));

  logic                      entry_valid;
  logic [cwl_pkg::PORT_W-1:0] entry_local_port;
  logic [cwl_pkg::HOST_W-1:0] entry_remote_host;
  logic [cwl_pkg::PORT_W-1:0] entry_remote_port;

  logic            addressed;
  logic            port_ok;
  logic            slot_null;
  logic            query_null;
  logic            host_eq;
  logic            rport_eq;
  logic            is_exact;
  logic            is_wild;
  cwl_pkg::token_t tok_next;

  always_comb begin
    addressed  = ADDRESSABLE && (tok_in.slot == SLOT_ID);
    port_ok    = entry_valid && (entry_local_port == tok_in.local_port);
    slot_null  = (entry_remote_host == '0);
    query_null = (tok_in.remote_host == '0);
    host_eq    = (entry_remote_host == tok_in.remote_host);
    rport_eq   = (entry_remote_port == tok_in.remote_port);
    is_exact   = port_ok && ((slot_null && query_null) ||
                             (!slot_null && !query_null && host_eq && rport_eq));
    is_wild    = port_ok && ((slot_null != query_null) ||
                             (!slot_null && !query_null && host_eq && !rport_eq &&
                              (entry_remote_port == '0)));

    tok_next = tok_in;
    if (tok_in.valid && (tok_in.command == cwl_pkg::CMD_LOOKUP) && !tok_in.exact_found) begin
      if (is_exact) begin
        tok_next.exact_found = 1'b1;
        tok_next.exact_slot  = SLOT_ID;
      end else if (is_wild && tok_in.allow_wildcard && !tok_in.wild_found) begin
        tok_next.wild_found = 1'b1;
        tok_next.wild_slot  = SLOT_ID;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (tok_in.valid && addressed) begin
      unique case (tok_in.command)
        cwl_pkg::CMD_WRITE: begin
          entry_valid <= 1'b1;
        end
        cwl_pkg::CMD_INVALIDATE: begin
          entry_valid <= 1'b0;
        end
        default: begin
          entry_valid <= entry_valid;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in.valid && addressed && (tok_in.command == cwl_pkg::CMD_WRITE)) begin
      entry_local_port  <= tok_in.local_port;
      entry_remote_host <= tok_in.remote_host;
      entry_remote_port <= tok_in.remote_port;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_out.command        <= tok_next.command;
    tok_out.slot           <= tok_next.slot;
    tok_out.local_port     <= tok_next.local_port;
    tok_out.remote_host    <= tok_next.remote_host;
    tok_out.remote_port    <= tok_next.remote_port;
    tok_out.allow_wildcard <= tok_next.allow_wildcard;
    tok_out.exact_found    <= tok_next.exact_found;
    tok_out.exact_slot     <= tok_next.exact_slot;
    tok_out.wild_found     <= tok_next.wild_found;
    tok_out.wild_slot      <= tok_next.wild_slot;
  end

endmodule

### hdl/connection_wildcard_lookup.sv
// Top level: connection table built as a row of slot cells that a command word walks along.
//
//   channel   handshake           payload
//   command   start / busy        command, slot, local_port, remote_host, remote_port,
//                                 allow_wildcard
//   result    done (one cycle)    hit, hit_slot, wildcard_used
//
// A command walks one cell per cycle, passing every cell register and then the done
// register between acceptance and its done strobe; the length of the cell row sets that delay.
// busy stays high from acceptance until the cycle in which done is shown, and a new
// command may be accepted in that same cycle.
// Synchronous reset clears every slot's valid flag and the control state at once.
// The receiver cannot stall: each result is shown for exactly one cycle.
module connection_wildcard_lookup #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [3:0]  slot,
  input  logic [15:0] local_port,
  input  logic [47:0] remote_host,
  input  logic [15:0] remote_port,
  input  logic        allow_wildcard,
  output logic        done,
  output logic        hit,
  output logic [3:0]  hit_slot,
  output logic        wildcard_used
);

  cwl_pkg::token_t chain [DEPTH+1];
  cwl_pkg::token_t head;
  cwl_pkg::token_t tail;

  logic busy_next;

  always_comb begin
    head.valid          = start && !busy;
    head.command        = command;
    head.slot           = slot;
    head.local_port     = local_port;
    head.remote_host    = remote_host;
    head.remote_port    = remote_port;
    head.allow_wildcard = allow_wildcard;
    head.exact_found    = 1'b0;
    head.exact_slot     = '0;
    head.wild_found     = 1'b0;
    head.wild_slot      = '0;
  end

  assign chain[0] = head;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cwl_cell #(
      .IDX(i)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .tok_in (chain[i]),
      .tok_out(chain[i+1])
    );
  end

  assign tail = chain[DEPTH];

  always_comb begin
    busy_next = busy;
    if (tail.valid) begin
      busy_next = 1'b0;
    end else if (start && !busy) begin
      busy_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= busy_next;
      done <= tail.valid;
    end
  end

  // Writes, invalidates and unused codes never set a found flag, so they report all zero.
  always_ff @(posedge clk) begin
    if (tail.valid) begin
      hit           <= tail.exact_found || tail.wild_found;
      wildcard_used <= !tail.exact_found && tail.wild_found;
      if (tail.exact_found) begin
        hit_slot <= tail.exact_slot;
      end else if (tail.wild_found) begin
        hit_slot <= tail.wild_slot;
      end else begin
        hit_slot <= '0;
      end
    end
  end

endmodule

### bench/connection_wildcard_lookup_tb.sv
// Self-checking bench for the connection table lookup: random and directed command words.
module connection_wildcard_lookup_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int RANDOM_WORDS = 1150;
  localparam int QUIET_TAIL = 150;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [47:0] HOST_ALL = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {MATCH_EXACT, MATCH_WILD, MATCH_NONE} match_t;

  typedef struct {
    logic [1:0]  command;
    logic [3:0]  slot;
    logic [15:0] local_port;
    logic [47:0] remote_host;
    logic [15:0] remote_port;
    logic        allow_wildcard;
    bit          drain;
    int unsigned gap;
  } cmd_word_t;

  typedef struct {
    logic       hit;
    logic [3:0] hit_slot;
    logic       wildcard_used;
  } lookup_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command = cwl_pkg::CMD_WRITE;
  logic [3:0]  slot = '0;
  logic [15:0] local_port = '0;
  logic [47:0] remote_host = '0;
  logic [15:0] remote_port = '0;
  logic        allow_wildcard = 1'b0;
  logic        done;
  logic        hit;
  logic [3:0]  hit_slot;
  logic        wildcard_used;

  // Shadow copy of the connection table.
  logic        tbl_valid [DEPTH];
  logic [15:0] tbl_lport [DEPTH];
  logic [47:0] tbl_host [DEPTH];
  logic [15:0] tbl_rport [DEPTH];

  logic [15:0] lport_pool [4];
  logic [47:0] host_pool [4];
  logic [15:0] rport_pool [4];

  cmd_word_t   pending_q[$];
  lookup_res_t expected_q[$];
  cmd_word_t   cur_word;
  int          items_sent = 0;
  int          results_seen = 0;
  int          total_words = 0;
  int          fail_count = 0;
  int unsigned idle_left = 0;
  bit          gap_armed = 1'b0;

  connection_wildcard_lookup #(.DEPTH(DEPTH)) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .slot(slot),
    .local_port(local_port),
    .remote_host(remote_host),
    .remote_port(remote_port),
    .allow_wildcard(allow_wildcard),
    .done(done),
    .hit(hit),
    .hit_slot(hit_slot),
    .wildcard_used(wildcard_used)
  );

  always #5 clk = ~clk;

  function automatic match_t grade_slot(int i, cmd_word_t w);
    if (!tbl_valid[i] || tbl_lport[i] != w.local_port) return MATCH_NONE;
    if (tbl_host[i] == '0) return (w.remote_host != '0) ? MATCH_WILD : MATCH_EXACT;
    if (w.remote_host == '0) return MATCH_WILD;
    if (tbl_host[i] != w.remote_host) return MATCH_NONE;
    if (tbl_rport[i] == w.remote_port) return MATCH_EXACT;
    return (tbl_rport[i] == '0) ? MATCH_WILD : MATCH_NONE;
  endfunction

  // Applies one accepted word to the shadow table and returns the result it should give.
  function automatic lookup_res_t apply_word(cmd_word_t w);
    lookup_res_t r;
    match_t      m;
    bit          wild_seen;
    logic [3:0]  wild_at;
    r.hit = 1'b0;
    r.hit_slot = '0;
    r.wildcard_used = 1'b0;
    wild_seen = 1'b0;
    wild_at = '0;
    case (w.command)
      cwl_pkg::CMD_WRITE: begin
        tbl_valid[w.slot] = 1'b1;
        tbl_lport[w.slot] = w.local_port;
        tbl_host[w.slot] = w.remote_host;
        tbl_rport[w.slot] = w.remote_port;
      end
      cwl_pkg::CMD_INVALIDATE: begin
        tbl_valid[w.slot] = 1'b0;
      end
      cwl_pkg::CMD_LOOKUP: begin
        for (int i = 0; i < DEPTH; i++) begin
          m = grade_slot(i, w);
          if (m == MATCH_EXACT) begin
            r.hit = 1'b1;
            r.hit_slot = 4'(i);
            break;
          end
          if (m == MATCH_WILD && w.allow_wildcard && !wild_seen) begin
            wild_seen = 1'b1;
            wild_at = 4'(i);
          end
        end
        if (!r.hit && wild_seen) begin
          r.hit = 1'b1;
          r.hit_slot = wild_at;
          r.wildcard_used = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic cmd_word_t mk(logic [1:0] c, logic [3:0] s, logic [15:0] lp,
                                   logic [47:0] h, logic [15:0] rp, logic a);
    cmd_word_t w;
    w.command = c;
    w.slot = s;
    w.local_port = lp;
    w.remote_host = h;
    w.remote_port = rp;
    w.allow_wildcard = a;
    w.drain = 1'b0;
    w.gap = 0;
    return w;
  endfunction

  // Values come mostly from small pools so that lookups find stored connections often.
  function automatic cmd_word_t random_word();
    cmd_word_t   w;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 38) w.command = cwl_pkg::CMD_WRITE;
    else if (pick < 48) w.command = cwl_pkg::CMD_INVALIDATE;
    else if (pick < 96) w.command = cwl_pkg::CMD_LOOKUP;
    else w.command = CMD_UNUSED;
    w.slot = 4'($urandom);
    w.local_port = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                               : lport_pool[$urandom_range(0, 3)];
    w.remote_host = ($urandom_range(0, 4) == 0) ? {16'($urandom), 32'($urandom)}
                                                : host_pool[$urandom_range(0, 3)];
    w.remote_port = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                : rport_pool[$urandom_range(0, 3)];
    w.allow_wildcard = 1'($urandom);
    w.drain = 1'b0;
    w.gap = 0;
    return w;
  endfunction

  // Driver: offers the next word, with idle bursts and the odd pause until the table is quiet.
  always @(posedge clk) begin
    cmd_word_t nxt;
    bit        accepted;
    bit        launch;
    int        in_flight;
    if (rst) begin
      start <= 1'b0;
      idle_left = 0;
      gap_armed = 1'b0;
    end else begin
      accepted = start && !busy;
      launch = 1'b0;
      if (accepted) begin
        expected_q.push_back(apply_word(cur_word));
        items_sent <= items_sent + 1;
      end
      in_flight = items_sent + int'(accepted) - results_seen;
      if ((!start || accepted) && pending_q.size() != 0) begin
        if (!gap_armed) begin
          idle_left = pending_q[0].gap;
          gap_armed = 1'b1;
        end
        if (idle_left != 0) begin
          idle_left--;
        end else if (!(pending_q[0].drain && in_flight != 0)) begin
          nxt = pending_q.pop_front();
          gap_armed = 1'b0;
          launch = 1'b1;
        end
      end
      if (launch) begin
        cur_word = nxt;
        start <= 1'b1;
        command <= nxt.command;
        slot <= nxt.slot;
        local_port <= nxt.local_port;
        remote_host <= nxt.remote_host;
        remote_port <= nxt.remote_port;
        allow_wildcard <= nxt.allow_wildcard;
      end else if (accepted) begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every done strobe carries one result word.
  always @(posedge clk) begin
    lookup_res_t want;
    if (!rst && done) begin
      results_seen <= results_seen + 1;
      if (expected_q.size() == 0) begin
        $error("unexpected result word: hit=%0b hit_slot=%0d wildcard_used=%0b",
               hit, hit_slot, wildcard_used);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (hit !== want.hit) begin
          $error("hit: expected %0b, got %0b", want.hit, hit);
          fail_count++;
        end
        if (hit_slot !== want.hit_slot) begin
          $error("hit_slot: expected %0d, got %0d", want.hit_slot, hit_slot);
          fail_count++;
        end
        if (wildcard_used !== want.wildcard_used) begin
          $error("wildcard_used: expected %0b, got %0b", want.wildcard_used, wildcard_used);
          fail_count++;
        end
      end
    end
  end

  initial begin
    cmd_word_t w;
    for (int i = 0; i < DEPTH; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_lport[i] = '0;
      tbl_host[i] = '0;
      tbl_rport[i] = '0;
    end
    lport_pool = '{16'h0000, 16'hFFFF, 16'($urandom), 16'($urandom)};
    host_pool = '{48'h0, HOST_ALL, {16'($urandom), 32'($urandom)},
                  {16'($urandom), 32'($urandom)}};
    rport_pool = '{16'h0000, 16'hFFFF, 16'($urandom), 16'($urandom)};

    pending_q.push_back(mk(cwl_pkg::CMD_LOOKUP, 4'd0, 16'h0, 48'h0, 16'h0, 1'b1));
    pending_q.push_back(mk(cwl_pkg::CMD_WRITE, 4'd0, 16'h0, 48'h0, 16'h0, 1'b0));
    // Null hosts on both sides match exactly whatever the ports.
    pending_q.push_back(mk(cwl_pkg::CMD_LOOKUP, 4'd0, 16'h0, 48'h0, 16'h1234, 1'b0));
    pending_q.push_back(mk(cwl_pkg::CMD_WRITE, 4'd15, 16'hFFFF, HOST_ALL, 16'hFFFF, 1'b1));
    pending_q.push_back(mk(cwl_pkg::CMD_LOOKUP, 4'd0, 16'hFFFF, HOST_ALL, 16'hFFFF, 1'b0));
    pending_q.push_back(mk(cwl_pkg::CMD_LOOKUP, 4'd0, 16'hFFFF, HOST_ALL, 16'h1234, 1'b1));
    // A stored port of zero turns a port mismatch into a wildcard match.
    pending_q.push_back(mk(cwl_pkg::CMD_WRITE, 4'd3, 16'hFFFF, HOST_ALL, 16'h0, 1'b0));
    pending_q.push_back(mk(cwl_pkg::CMD_LOOKUP, 4'd0, 16'hFFFF, HOST_ALL, 16'h1234, 1'b1));
    pending_q.push_back(mk(cwl_pkg::CMD_LOOKUP, 4'd0, 16'hFFFF, HOST_ALL, 16'h1234, 1'b0));
    pending_q.push_back(mk(cwl_pkg::CMD_LOOKUP, 4'd0, 16'hFFFF, 48'h0, 16'h5, 1'b1));
    pending_q.push_back(mk(cwl_pkg::CMD_LOOKUP, 4'd0, 16'hFFFE, HOST_ALL, 16'hFFFF, 1'b1));
    pending_q.push_back(mk(cwl_pkg::CMD_WRITE, 4'd5, 16'h7, 48'h0, 16'd99, 1'b0));
    pending_q.push_back(mk(cwl_pkg::CMD_LOOKUP, 4'd0, 16'h7, 48'h1111_2222, 16'h1, 1'b1));
    pending_q.push_back(mk(cwl_pkg::CMD_LOOKUP, 4'd0, 16'h7, 48'h1111_2222, 16'h1, 1'b0));
    // An exact match in a higher slot beats a wildcard in a lower one.
    pending_q.push_back(mk(cwl_pkg::CMD_WRITE, 4'd2, 16'h9, 48'h0, 16'h0, 1'b0));
    pending_q.push_back(mk(cwl_pkg::CMD_WRITE, 4'd8, 16'h9, 48'hAB_CDEF, 16'd80, 1'b0));
    pending_q.push_back(mk(cwl_pkg::CMD_LOOKUP, 4'd0, 16'h9, 48'hAB_CDEF, 16'd80, 1'b1));
    pending_q.push_back(mk(cwl_pkg::CMD_WRITE, 4'd6, 16'h9, 48'hAB_CDEF, 16'h0, 1'b0));
    pending_q.push_back(mk(cwl_pkg::CMD_LOOKUP, 4'd0, 16'h9, 48'hAB_CDEF, 16'd81, 1'b1));
    pending_q.push_back(mk(cwl_pkg::CMD_INVALIDATE, 4'd2, 16'hFFFF, HOST_ALL, 16'hFFFF, 1'b1));
    pending_q.push_back(mk(cwl_pkg::CMD_LOOKUP, 4'd0, 16'h9, 48'hAB_CDEF, 16'd81, 1'b1));
    pending_q.push_back(mk(CMD_UNUSED, 4'd8, 16'h9, 48'hAB_CDEF, 16'd80, 1'b1));
    pending_q.push_back(mk(cwl_pkg::CMD_INVALIDATE, 4'd15, 16'h0, 48'h0, 16'h0, 1'b0));
    w = mk(cwl_pkg::CMD_LOOKUP, 4'd0, 16'hFFFF, HOST_ALL, 16'hFFFF, 1'b1);
    w.drain = 1'b1;
    pending_q.push_back(w);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      w = random_word();
      // Idle bursts come in stretches, with quiet stretches and a quiet tail.
      if (n < RANDOM_WORDS - QUIET_TAIL && ((n / 90) % 3) != 2 && $urandom_range(0, 3) == 0)
        w.gap = $urandom_range(1, 18);
      if (n == 500 || $urandom_range(0, 99) == 0) w.drain = 1'b1;
      pending_q.push_back(w);
    end
    total_words = pending_q.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (items_sent != total_words || results_seen != items_sent) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d expected result words never arrived", expected_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("status: fail");
    $finish;
  end

endmodule
